// File: hdl/atpf_pkg.sv
package atpf_pkg;

    localparam int unsigned ChanW   = 8;
    localparam int unsigned GainW   = 13;
    localparam int unsigned ModeW   = 2;
    localparam int unsigned IndexW  = 3;
    localparam int unsigned SumW    = 10;
    localparam int unsigned MultW   = 19;
    localparam int unsigned ProdW   = 28;
    localparam int unsigned RecipW  = 10;
    localparam int unsigned RecipSh = 11;
    localparam logic [RecipW-1:0] RECIP3 = RecipW'(683);
    localparam logic [MultW-1:0] UNITY = MultW'(65535);

    localparam logic [IndexW-1:0] REG_RED_GAIN   = 3'd0;
    localparam logic [IndexW-1:0] REG_GREEN_GAIN = 3'd1;
    localparam logic [IndexW-1:0] REG_BLUE_GAIN  = 3'd2;
    localparam logic [IndexW-1:0] REG_GREY_MODE  = 3'd3;
    localparam logic [IndexW-1:0] REG_BOOST      = 3'd4;

    localparam logic [ModeW-1:0] GREY_NONE = 2'd0;
    localparam logic [ModeW-1:0] GREY_MAX  = 2'd1;
    localparam logic [ModeW-1:0] GREY_AVG  = 2'd2;

    typedef struct packed {
        logic [GainW-1:0] red_gain;
        logic [GainW-1:0] green_gain;
        logic [GainW-1:0] blue_gain;
        logic [ModeW-1:0] grey_mode;
        logic             boost;
        logic             bypass;
    } t_cfg;

endpackage

// File: hdl/atpf_cfg.sv
module atpf_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [atpf_pkg::IndexW-1:0]        i_cfg_index,
    input  logic [atpf_pkg::GainW-1:0]         i_cfg_data,
    output atpf_pkg::t_cfg                     o_cfg
);

    logic [atpf_pkg::GainW-1:0] r_red_gain, r_green_gain, r_blue_gain;
    logic [atpf_pkg::ModeW-1:0] r_grey_mode;
    logic                       r_boost;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_gain   <= '0;
            r_green_gain <= '0;
            r_blue_gain  <= '0;
            r_grey_mode  <= atpf_pkg::GREY_NONE;
            r_boost      <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                atpf_pkg::REG_RED_GAIN:   r_red_gain   <= i_cfg_data;
                atpf_pkg::REG_GREEN_GAIN: r_green_gain <= i_cfg_data;
                atpf_pkg::REG_BLUE_GAIN:  r_blue_gain  <= i_cfg_data;
                atpf_pkg::REG_GREY_MODE:  r_grey_mode  <= i_cfg_data[atpf_pkg::ModeW-1:0];
                atpf_pkg::REG_BOOST:      r_boost      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.red_gain   = r_red_gain;
        o_cfg.green_gain = r_green_gain;
        o_cfg.blue_gain  = r_blue_gain;
        o_cfg.grey_mode  = r_grey_mode;
        o_cfg.boost      = r_boost;
        o_cfg.bypass     = (r_red_gain == '0) && (r_green_gain == '0) && (r_blue_gain == '0)
                        && (r_grey_mode == atpf_pkg::GREY_NONE) && !r_boost;
    end

endmodule

// File: hdl/atpf_front.sv
module atpf_front (
    input  logic                        i_clk,
    input  logic                        i_en1,
    input  logic                        i_en2,
    input  atpf_pkg::t_cfg              i_cfg,
    input  logic [atpf_pkg::ChanW-1:0]  i_alpha,
    input  logic [atpf_pkg::ChanW-1:0]  i_red,
    input  logic [atpf_pkg::ChanW-1:0]  i_green,
    input  logic [atpf_pkg::ChanW-1:0]  i_blue,
    input  logic                        i_last,
    output logic [atpf_pkg::ChanW-1:0]  o_alpha,
    output logic [atpf_pkg::ChanW-1:0]  o_red,
    output logic [atpf_pkg::ChanW-1:0]  o_green,
    output logic [atpf_pkg::ChanW-1:0]  o_blue,
    output logic                        o_last
);

    localparam int unsigned AvgProdW = atpf_pkg::SumW + atpf_pkg::RecipW;

    logic [atpf_pkg::ChanW-1:0] r_a1, r_r1, r_g1, r_b1, r_max1;
    logic [atpf_pkg::SumW-1:0]  r_sum1;
    logic                       r_last1;
    logic [atpf_pkg::ChanW-1:0] n_max;
    logic [atpf_pkg::ChanW-1:0] r_a2, r_r2, r_g2, r_b2;
    logic                       r_last2;
    logic [AvgProdW-1:0]        avg_prod;
    logic [atpf_pkg::ChanW-1:0] avg, gr, gg, gb, half_a;
    logic [atpf_pkg::ChanW-1:0] n_r2, n_g2, n_b2;

    always_comb begin
        n_max = (i_red > i_green) ? i_red : i_green;
        if (i_blue > n_max) begin
            n_max = i_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_a1    <= i_alpha;
            r_r1    <= i_red;
            r_g1    <= i_green;
            r_b1    <= i_blue;
            r_last1 <= i_last;
            r_max1  <= n_max;
            r_sum1  <= atpf_pkg::SumW'(i_red) + atpf_pkg::SumW'(i_green)
                     + atpf_pkg::SumW'(i_blue);
        end
    end

    // The sum is at most 765, where multiplying by 683/2048 gives the exact floor of a third.
    assign avg_prod = AvgProdW'(r_sum1) * AvgProdW'(atpf_pkg::RECIP3);
    assign avg      = avg_prod[atpf_pkg::RecipSh +: atpf_pkg::ChanW];
    assign half_a   = {1'b0, r_a1[atpf_pkg::ChanW-1:1]};

    always_comb begin
        unique case (i_cfg.grey_mode)
            atpf_pkg::GREY_MAX: begin
                gr = r_max1;
                gg = r_max1;
                gb = r_max1;
            end
            atpf_pkg::GREY_AVG: begin
                gr = avg;
                gg = avg;
                gb = avg;
            end
            default: begin
                gr = r_r1;
                gg = r_g1;
                gb = r_b1;
            end
        endcase
        if (i_cfg.bypass) begin
            n_r2 = r_r1;
            n_g2 = r_g1;
            n_b2 = r_b1;
        end else if (i_cfg.boost) begin
            n_r2 = {1'b0, gr[atpf_pkg::ChanW-1:1]} + half_a;
            n_g2 = {1'b0, gg[atpf_pkg::ChanW-1:1]} + half_a;
            n_b2 = {1'b0, gb[atpf_pkg::ChanW-1:1]} + half_a;
        end else begin
            n_r2 = gr;
            n_g2 = gg;
            n_b2 = gb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_a2    <= r_a1;
            r_last2 <= r_last1;
            r_r2    <= n_r2;
            r_g2    <= n_g2;
            r_b2    <= n_b2;
        end
    end

    assign o_alpha = r_a2;
    assign o_red   = r_r2;
    assign o_green = r_g2;
    assign o_blue  = r_b2;
    assign o_last  = r_last2;

endmodule

// File: hdl/atpf_scale.sv
module atpf_scale (
    input  logic                        i_clk,
    input  logic                        i_en3,
    input  logic                        i_en4,
    input  logic                        i_bypass,
    input  logic [atpf_pkg::GainW-1:0]  i_gain,
    input  logic [atpf_pkg::ChanW-1:0]  i_value,
    output logic [atpf_pkg::ChanW-1:0]  o_value
);

    localparam int unsigned QuotW = atpf_pkg::ProdW - 1 - 16;

    logic signed [atpf_pkg::MultW-1:0] mult;
    logic signed [atpf_pkg::ProdW-1:0] r_prod3;
    logic [atpf_pkg::ChanW-1:0]        r_v3, r_out4, n_out4;
    logic [QuotW-1:0]                  quot;

    assign mult = $signed(atpf_pkg::UNITY)
                + $signed({{2{i_gain[atpf_pkg::GainW-1]}}, i_gain, 4'b0000});

    always_ff @(posedge i_clk) begin
        if (i_en3) begin
            r_prod3 <= atpf_pkg::ProdW'($signed({1'b0, i_value})) * atpf_pkg::ProdW'(mult);
            r_v3    <= i_value;
        end
    end

    assign quot = r_prod3[atpf_pkg::ProdW-2:16];

    always_comb begin
        if (i_bypass) begin
            n_out4 = r_v3;
        end else if (r_prod3[atpf_pkg::ProdW-1]) begin
            n_out4 = '0;
        end else if (quot > QuotW'(255)) begin
            n_out4 = '1;
        end else begin
            n_out4 = quot[atpf_pkg::ChanW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en4) begin
            r_out4 <= n_out4;
        end
    end

    assign o_value = r_out4;

endmodule

// File: hdl/argb_pixel_tint_filter.sv
// Four-stage pipeline: the input word is registered in stage one at the accepting edge and moves
// through stages two, three and four. Throughput is one pixel per clock unless the output stalls.
// A stage holds only when the one after it is full and stalled, so bubbles are squeezed out;
// input is refused only while all four stages are full and the output is stalled.
// Synchronous active-low reset clears the stage valid bits and the configuration registers.
// Configuration writes are always accepted and take effect at the accepting edge.
module argb_pixel_tint_filter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [atpf_pkg::ChanW-1:0]         i_alpha_in,
    input  logic [atpf_pkg::ChanW-1:0]         i_red_in,
    input  logic [atpf_pkg::ChanW-1:0]         i_green_in,
    input  logic [atpf_pkg::ChanW-1:0]         i_blue_in,
    input  logic                               i_last_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [atpf_pkg::ChanW-1:0]         o_alpha_out,
    output logic [atpf_pkg::ChanW-1:0]         o_red_out,
    output logic [atpf_pkg::ChanW-1:0]         o_green_out,
    output logic [atpf_pkg::ChanW-1:0]         o_blue_out,
    output logic                               o_last_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [atpf_pkg::IndexW-1:0]        i_cfg_index,
    input  logic [atpf_pkg::GainW-1:0]         i_cfg_data
);

    atpf_pkg::t_cfg cfg;

    logic r_v1, r_v2, r_v3, r_v4;
    logic adv1, adv2, adv3, adv4;
    logic [atpf_pkg::ChanW-1:0] f_alpha, f_red, f_green, f_blue;
    logic f_last;
    logic [atpf_pkg::ChanW-1:0] r_a3, r_a4;
    logic r_last3, r_last4;

    assign adv4 = !r_v4 || i_out_ready;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign o_in_ready  = adv1;
    assign o_out_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_in_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    atpf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    atpf_front u_front (
        .i_clk   (i_clk),
        .i_en1   (adv1),
        .i_en2   (adv2),
        .i_cfg   (cfg),
        .i_alpha (i_alpha_in),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .i_last  (i_last_in),
        .o_alpha (f_alpha),
        .o_red   (f_red),
        .o_green (f_green),
        .o_blue  (f_blue),
        .o_last  (f_last)
    );

    atpf_scale u_scale_red (
        .i_clk    (i_clk),
        .i_en3    (adv3),
        .i_en4    (adv4),
        .i_bypass (cfg.bypass),
        .i_gain   (cfg.red_gain),
        .i_value  (f_red),
        .o_value  (o_red_out)
    );

    atpf_scale u_scale_green (
        .i_clk    (i_clk),
        .i_en3    (adv3),
        .i_en4    (adv4),
        .i_bypass (cfg.bypass),
        .i_gain   (cfg.green_gain),
        .i_value  (f_green),
        .o_value  (o_green_out)
    );

    atpf_scale u_scale_blue (
        .i_clk    (i_clk),
        .i_en3    (adv3),
        .i_en4    (adv4),
        .i_bypass (cfg.bypass),
        .i_gain   (cfg.blue_gain),
        .i_value  (f_blue),
        .o_value  (o_blue_out)
    );

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_a3    <= f_alpha;
            r_last3 <= f_last;
        end
        if (adv4) begin
            r_a4    <= r_a3;
            r_last4 <= r_last3;
        end
    end

    assign o_alpha_out = r_a4;
    assign o_last_out  = r_last4;

endmodule
